[hw/rtl/rccc_pkg.sv]
package rccc_pkg;

  // channel plan
  localparam int unsigned CHANNEL_BASE = 11;
  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned IDX_W        = $clog2(NUM_CHANNELS);

  localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(4 % NUM_CHANNELS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_CHANNELS - 1);
  localparam logic [7:0]       CHAN_LO   = 8'(CHANNEL_BASE);
  localparam logic [7:0]       CHAN_HI   = 8'(CHANNEL_BASE + NUM_CHANNELS - 1);

  // item modes
  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;
  localparam logic [1:0] MODE_RX     = 2'd3;

  // report codes
  localparam logic [1:0] REP_NONE    = 2'd0;
  localparam logic [1:0] REP_CHANGED = 2'd1;
  localparam logic [1:0] REP_QUERY   = 2'd2;
  localparam logic [1:0] REP_INVALID = 2'd3;

  // command characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_N_LO  = 8'h6E;
  localparam logic [7:0] CH_N_UP  = 8'h4E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_P_LO  = 8'h70;
  localparam logic [7:0] CH_P_UP  = 8'h50;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // register map
  localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] REG_BLINK_HALF = 2'd1;
  localparam logic [7:0] DEBOUNCE_RESET   = 8'd50;
  localparam logic [7:0] BLINK_HALF_RESET = 8'd30;

  // blink sequence lengths in LED toggles
  localparam logic [2:0] TOGGLES_SWITCH = 3'd4;
  localparam logic [2:0] TOGGLES_RX     = 3'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic [4:0] channel;
    logic [1:0] report;
    logic       led_level;
  } out_t;

  // events handed to the blinker: tick and rx from the request, switched from the channel control
  typedef struct packed {
    logic tick;
    logic rx;
    logic switched;
  } blink_req_t;

endpackage

[hw/rtl/radio_channel_command_control.sv]
// Radio channel command control.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per serial
// character, button press, millisecond tick or packet-received event.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): exactly one response
// per request, in order: current channel, report code and LED level.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 debounce_ms, index 1
// blink_half_ms; always ready, write only while the block is idle.
// A request moves from the input register into the response register,
// from which it can leave. Throughput: one request per cycle while the
// output is not stalled; all the work for a request is one pass of short
// logic between the two registers.
// The state (channel, digit buffer, ms counter, blinker) commits at the edge
// where the request moves into the response register.
// Reset (async, active low): channel 15, no pending digits, counters zero,
// LED off, debounce_ms 50, blink_half_ms 30. No clearing pass is needed.
// Output stall: the response register holds; the input register fills and
// then in_stall_o rises, so at most two requests sit inside the block.
module radio_channel_command_control (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rccc_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rccc_pkg::out_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  // input register
  logic          s1_valid_q, s1_valid_d;
  rccc_pkg::in_t s1_req_q;

  // response register
  logic           out_valid_q, out_valid_d;
  rccc_pkg::out_t out_q;

  // configuration
  logic [7:0] debounce_q, blink_half_q;

  logic                 out_free;
  logic                 advance;
  logic                 in_accept;
  logic [31:0]          ms_count;
  logic [4:0]           channel;
  logic [1:0]           report;
  logic                 switched;
  logic                 led;
  rccc_pkg::blink_req_t blink_req;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  rccc_chan_ctrl u_chan_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .req_i         (s1_req_q),
    .ms_count_i    (ms_count),
    .debounce_ms_i (debounce_q),
    .channel_o     (channel),
    .report_o      (report),
    .switched_o    (switched)
  );

  assign blink_req.tick     = (s1_req_q.mode == rccc_pkg::MODE_TICK);
  assign blink_req.rx       = (s1_req_q.mode == rccc_pkg::MODE_RX);
  assign blink_req.switched = switched;

  rccc_blinker u_blinker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .req_i           (blink_req),
    .blink_half_ms_i (blink_half_q),
    .ms_count_o      (ms_count),
    .led_o           (led)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) s1_req_q <= in_req_i;
    if (advance) begin
      out_q.channel   <= channel;
      out_q.report    <= report;
      out_q.led_level <= led;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= rccc_pkg::DEBOUNCE_RESET;
      blink_half_q <= rccc_pkg::BLINK_HALF_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rccc_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        rccc_pkg::REG_BLINK_HALF: blink_half_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[hw/rtl/rccc_chan_ctrl.sv]
module rccc_chan_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  rccc_pkg::in_t                    req_i,
  input  logic [31:0]                      ms_count_i,
  input  logic [7:0]                       debounce_ms_i,
  output logic [4:0]                       channel_o,
  output logic [1:0]                       report_o,
  output logic                             switched_o
);

  logic [rccc_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       num_valid_q, num_valid_d;
  logic [7:0]                 num_acc_q, num_acc_d;
  logic [31:0]                last_press_q, last_press_d;

  logic [rccc_pkg::IDX_W-1:0] idx_up, idx_dn;
  logic [7:0]                 base;
  logic [11:0]                acc_next;
  logic [31:0]                since_press;
  logic [7:0]                 c;

  assign c      = req_i.char_code;
  assign idx_up = (idx_q == rccc_pkg::IDX_LAST) ? '0 : idx_q + rccc_pkg::IDX_W'(1);
  assign idx_dn = (idx_q == '0) ? rccc_pkg::IDX_LAST : idx_q - rccc_pkg::IDX_W'(1);
  assign base   = num_valid_q ? num_acc_q : 8'd0;
  assign acc_next = 12'(base) * 12'd10 + 12'(c - rccc_pkg::CH_ZERO);
  assign since_press = ms_count_i - last_press_q;

  always_comb begin
    idx_d        = idx_q;
    num_valid_d  = num_valid_q;
    num_acc_d    = num_acc_q;
    last_press_d = last_press_q;
    report_o     = rccc_pkg::REP_NONE;
    switched_o   = 1'b0;
    unique case (req_i.mode)
      rccc_pkg::MODE_CHAR: begin
        num_valid_d = 1'b0;
        num_acc_d   = 8'd0;
        unique case (c) inside
          rccc_pkg::CH_PLUS, rccc_pkg::CH_N_LO, rccc_pkg::CH_N_UP: begin
            idx_d      = idx_up;
            report_o   = rccc_pkg::REP_CHANGED;
            switched_o = 1'b1;
          end
          rccc_pkg::CH_MINUS, rccc_pkg::CH_P_LO, rccc_pkg::CH_P_UP: begin
            idx_d      = idx_dn;
            report_o   = rccc_pkg::REP_CHANGED;
            switched_o = 1'b1;
          end
          rccc_pkg::CH_QUERY: begin
            report_o = rccc_pkg::REP_QUERY;
          end
          [rccc_pkg::CH_ZERO:rccc_pkg::CH_NINE]: begin
            num_valid_d = 1'b1;
            num_acc_d   = (acc_next > 12'd255) ? 8'd255 : acc_next[7:0];
          end
          rccc_pkg::CH_CR, rccc_pkg::CH_LF: begin
            if (num_valid_q) begin
              if (num_acc_q >= rccc_pkg::CHAN_LO && num_acc_q <= rccc_pkg::CHAN_HI) begin
                idx_d      = rccc_pkg::IDX_W'(num_acc_q - rccc_pkg::CHAN_LO);
                report_o   = rccc_pkg::REP_CHANGED;
                switched_o = 1'b1;
              end else begin
                report_o = rccc_pkg::REP_INVALID;
              end
            end
          end
          default: ;  // any other character only drops the pending number
        endcase
      end
      rccc_pkg::MODE_BUTTON: begin
        if (since_press >= 32'(debounce_ms_i)) begin
          last_press_d = ms_count_i;
          idx_d        = idx_up;
          report_o     = rccc_pkg::REP_CHANGED;
          switched_o   = 1'b1;
        end
      end
      default: ;  // ticks and receive events leave the channel alone
    endcase
  end

  assign channel_o = 5'(rccc_pkg::CHANNEL_BASE + 32'(idx_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= rccc_pkg::IDX_RESET;
      num_valid_q  <= 1'b0;
      num_acc_q    <= 8'd0;
      last_press_q <= 32'd0;
    end else if (en_i) begin
      idx_q        <= idx_d;
      num_valid_q  <= num_valid_d;
      num_acc_q    <= num_acc_d;
      last_press_q <= last_press_d;
    end
  end

endmodule

[hw/rtl/rccc_blinker.sv]
module rccc_blinker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rccc_pkg::blink_req_t req_i,
  input  logic [7:0]           blink_half_ms_i,
  output logic [31:0]          ms_count_o,
  output logic                 led_o
);

  logic [31:0] ms_q, ms_d;
  logic [31:0] next_q, next_d;
  logic [2:0]  left_q, left_d;
  logic        sw_q, sw_d;
  logic        rx_q, rx_d;
  logic        led_q, led_d;

  logic [31:0] ms_inc;
  logic [31:0] due_diff;
  logic [31:0] due_at;
  logic [2:0]  left_start;
  logic        active;

  assign ms_inc = ms_q + 32'd1;

  always_comb begin
    ms_d   = ms_q;
    next_d = next_q;
    left_d = left_q;
    sw_d   = sw_q | req_i.switched;
    rx_d   = rx_q | req_i.rx;
    led_d  = led_q;

    // start a new sequence when idle; switch wins over receive
    active     = 1'b1;
    left_start = left_q;
    due_at     = next_q;
    if (left_q == 3'd0) begin
      due_at = ms_inc;
      if (sw_q) begin
        left_start = rccc_pkg::TOGGLES_SWITCH;
      end else if (rx_q) begin
        left_start = rccc_pkg::TOGGLES_RX;
      end else begin
        active = 1'b0;
      end
    end
    due_diff = ms_inc - due_at;

    if (req_i.tick) begin
      ms_d = ms_inc;
      if (active) begin
        if (left_q == 3'd0) begin
          if (sw_q) sw_d = 1'b0;
          else      rx_d = 1'b0;
        end
        left_d = left_start;
        next_d = due_at;
        if (!due_diff[31]) begin
          led_d  = ~led_q;
          left_d = left_start - 3'd1;
          next_d = ms_inc + 32'(blink_half_ms_i);
        end
      end
    end
  end

  assign ms_count_o = ms_q;
  assign led_o      = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q   <= 32'd0;
      next_q <= 32'd0;
      left_q <= 3'd0;
      sw_q   <= 1'b0;
      rx_q   <= 1'b0;
      led_q  <= 1'b0;
    end else if (en_i) begin
      ms_q   <= ms_d;
      next_q <= next_d;
      left_q <= left_d;
      sw_q   <= sw_d;
      rx_q   <= rx_d;
      led_q  <= led_d;
    end
  end

endmodule

[tb/rccc_result_checker.sv]
module rccc_result_checker
  import rccc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_t        in_req_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_t       out_rsp_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  // shadow copy of the control state
  logic [7:0]       debounce_ms;
  logic [7:0]       blink_half_ms;
  logic [IDX_W-1:0] chan_idx;
  logic             digits_pending;
  logic [7:0]       digit_acc;
  logic [31:0]      ms_now;
  logic [31:0]      last_press_at;
  logic             switch_req;
  logic             rx_req;
  logic [2:0]       toggles_left;
  logic [31:0]      next_toggle_at;
  logic             led_lit;

  out_t expected_rsp_q[$];
  out_t expected_rsp;
  out_t predicted_rsp;
  int   fails;
  int   checked;

  task automatic step_channel(input logic up);
    if (up) chan_idx = (chan_idx == IDX_LAST) ? '0 : chan_idx + IDX_W'(1);
    else    chan_idx = (chan_idx == '0) ? IDX_LAST : chan_idx - IDX_W'(1);
    switch_req = 1'b1;
  endtask

  task automatic run_blinker();
    logic        busy;
    logic [31:0] lag;
    busy = 1'b1;
    if (toggles_left == '0) begin
      if (switch_req) begin
        switch_req   = 1'b0;
        toggles_left = TOGGLES_SWITCH;
      end else if (rx_req) begin
        rx_req       = 1'b0;
        toggles_left = TOGGLES_RX;
      end else begin
        busy = 1'b0;
      end
      if (busy) next_toggle_at = ms_now;
    end
    lag = ms_now - next_toggle_at;
    // toggle once the due time is reached (wrap-safe compare)
    if (busy && !lag[31]) begin
      led_lit        = ~led_lit;
      toggles_left   = toggles_left - 3'd1;
      next_toggle_at = ms_now + 32'(blink_half_ms);
    end
  endtask

  task automatic predict_response(input in_t req, output out_t rsp);
    logic [1:0]  rep;
    int unsigned acc;
    rep = REP_NONE;
    case (req.mode)
      MODE_CHAR: begin
        case (req.char_code)
          CH_PLUS, CH_N_LO, CH_N_UP: begin
            step_channel(1'b1);
            rep = REP_CHANGED;
            digits_pending = 1'b0;
            digit_acc      = '0;
          end
          CH_MINUS, CH_P_LO, CH_P_UP: begin
            step_channel(1'b0);
            rep = REP_CHANGED;
            digits_pending = 1'b0;
            digit_acc      = '0;
          end
          CH_QUERY: begin
            rep = REP_QUERY;
            digits_pending = 1'b0;
            digit_acc      = '0;
          end
          CH_CR, CH_LF: begin
            if (digits_pending) begin
              if (digit_acc >= CHAN_LO && digit_acc <= CHAN_HI) begin
                chan_idx   = IDX_W'(digit_acc - CHAN_LO);
                switch_req = 1'b1;
                rep        = REP_CHANGED;
              end else begin
                rep = REP_INVALID;
              end
            end
            digits_pending = 1'b0;
            digit_acc      = '0;
          end
          default: begin
            if (req.char_code >= CH_ZERO && req.char_code <= CH_NINE) begin
              acc = (digits_pending ? int'(digit_acc) : 0) * 10
                    + int'(req.char_code - CH_ZERO);
              digit_acc      = (acc > 255) ? 8'd255 : 8'(acc);
              digits_pending = 1'b1;
            end else begin
              digits_pending = 1'b0;
              digit_acc      = '0;
            end
          end
        endcase
      end
      MODE_BUTTON: begin
        if ((ms_now - last_press_at) >= 32'(debounce_ms)) begin
          last_press_at = ms_now;
          step_channel(1'b1);
          rep = REP_CHANGED;
        end
      end
      MODE_TICK: begin
        ms_now = ms_now + 32'd1;
        run_blinker();
      end
      default: rx_req = 1'b1;
    endcase
    rsp.channel   = 5'(CHANNEL_BASE + 32'(chan_idx));
    rsp.report    = rep;
    rsp.led_level = led_lit;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms    = DEBOUNCE_RESET;
      blink_half_ms  = BLINK_HALF_RESET;
      chan_idx       = IDX_RESET;
      digits_pending = 1'b0;
      digit_acc      = '0;
      ms_now         = '0;
      last_press_at  = '0;
      switch_req     = 1'b0;
      rx_req         = 1'b0;
      toggles_left   = '0;
      next_toggle_at = '0;
      led_lit        = 1'b0;
      expected_rsp_q.delete();
      fails          = 0;
      checked        = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE:   debounce_ms   = cfg_data_i;
          REG_BLINK_HALF: blink_half_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        predict_response(in_req_i, predicted_rsp);
        expected_rsp_q.push_back(predicted_rsp);
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response, actual %p", $time, out_rsp_i);
          fails++;
        end else begin
          expected_rsp = expected_rsp_q.pop_front();
          if (out_rsp_i.channel !== expected_rsp.channel) begin
            $display("%0t: channel mismatch, expected %0d, actual %0d",
                     $time, expected_rsp.channel, out_rsp_i.channel);
            fails++;
          end
          if (out_rsp_i.report !== expected_rsp.report) begin
            $display("%0t: report mismatch, expected %0d, actual %0d",
                     $time, expected_rsp.report, out_rsp_i.report);
            fails++;
          end
          if (out_rsp_i.led_level !== expected_rsp.led_level) begin
            $display("%0t: led_level mismatch, expected %0d, actual %0d",
                     $time, expected_rsp.led_level, out_rsp_i.led_level);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_rsp_q.size();
      checked_o    <= checked;
    end
  end

endmodule

[tb/radio_channel_command_control_tb.sv]
module radio_channel_command_control_tb;
  import rccc_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int GAP_MAX         = 16;
  // long output hold-off, long enough to back the block up into in_stall_o
  localparam int HOLD_CYCLES     = 300;
  // cycles with no handshake on any channel before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 3000;
  // settle time after the last response (two-register pipe plus margin)
  localparam int DRAIN_TAIL      = 8;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  in_t        in_req      = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  out_t       out_rsp;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index   = '0;
  logic [7:0] cfg_data    = '0;

  int fail_count;
  int pending;
  int checked;
  int n_sent      = 0;
  int in_gap_max  = GAP_MAX;
  int out_gap_max = GAP_MAX;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  // step commands for the random part; slot 7 of the draw is a noise byte
  logic [7:0] cmd_chars [7] = '{CH_PLUS, CH_N_LO, CH_N_UP, CH_MINUS,
                                CH_P_LO, CH_P_UP, CH_QUERY};

  // directed character stream:
  //  query, set the current channel (15) again, every step command,
  //  set 26, wrap up to 11 and back down to 26, an oversized number that
  //  saturates and is rejected, a bare CR, a number cleared by a stray
  //  character, and the byte extremes
  logic [7:0] directed_chars [25] = '{CH_QUERY, "1", "5", CH_CR,
                                      CH_PLUS, CH_N_LO, CH_N_UP,
                                      CH_MINUS, CH_P_LO, CH_P_UP,
                                      "2", "6", CH_LF,
                                      CH_PLUS, CH_MINUS,
                                      "9", "9", "9", CH_CR,
                                      CH_CR,
                                      "7", "x", CH_LF,
                                      8'h00, 8'hFF};

  always #HALF_PERIOD clk = ~clk;

  radio_channel_command_control DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rccc_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // zero for half the draws (always when max_gap is 0), else uniform from 0 to max_gap
  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0 || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  // One request: optional idle gap, then hold valid and payload until
  // an edge with in_stall low. Valid stays high into the next request
  // when that one has no gap, so valid only gets one update per step.
  task automatic send_request(input logic [1:0] mode, input logic [7:0] code);
    int gap;
    gap = draw_gap(in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= {mode, code};
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Stop offering and wait until every predicted response has been seen.
  // The first edge lets the checker's pending count catch the last request.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Response side: random stall before each response, or one long hold-off
  // when requested; the sender keeps going meanwhile.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = draw_gap(out_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: any accepted request, response or register write resets it.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         i;
    int         ph;
    int         r;
    int         v;
    int         phase_end;
    logic [7:0] dbn;
    logic [7:0] half;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values. A press right after reset
    // falls inside the debounce window and is ignored.
    send_request(MODE_BUTTON, 8'($urandom));
    for (i = 0; i < 25; i++) send_request(MODE_CHAR, directed_chars[i]);
    send_request(MODE_RX, 8'($urandom));
    send_request(MODE_TICK, 8'($urandom));

    // Random phases, each under its own register setting.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       begin dbn = 8'd0;   half = 8'd0;   end
        1:       begin dbn = 8'd255; half = 8'd255; end
        2:       begin dbn = 8'($urandom_range(0, 255)); half = 8'($urandom_range(1, 8)); end
        3:       begin dbn = 8'd3;   half = 8'd1;   end
        4:       begin dbn = 8'($urandom); half = 8'($urandom); end
        default: begin dbn = 8'($urandom_range(0, 20)); half = 8'($urandom_range(0, 20)); end
      endcase
      // registers change only with the block empty
      drain_block();
      write_config(REG_DEBOUNCE, dbn);
      write_config(REG_BLINK_HALF, half);

      // phase 2 backs the block up; phase 3 runs with no idling at all
      if (ph == 2) hold_req = 1'b1;
      in_gap_max  = (ph == 3) ? 0 : GAP_MAX;
      out_gap_max = (ph == 3) ? 0 : GAP_MAX;

      phase_end = n_sent + ITEMS_PER_PHASE;
      while (n_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          send_request(MODE_TICK, 8'($urandom));
        end else if (r < 40) begin
          send_request(MODE_BUTTON, 8'($urandom));
        end else if (r < 47) begin
          send_request(MODE_RX, 8'($urandom));
        end else if (r < 70) begin
          i = $urandom_range(0, 7);
          send_request(MODE_CHAR, (i < 7) ? cmd_chars[i] : 8'($urandom));
        end else begin
          // decimal set command, mostly near the channel range
          v = ($urandom_range(0, 3) != 0) ? $urandom_range(8, 30)
                                          : $urandom_range(0, 999);
          if ($urandom_range(0, 7) == 0) send_request(MODE_CHAR, CH_ZERO);
          if (v >= 100) send_request(MODE_CHAR, 8'(CH_ZERO + v / 100));
          if (v >= 10)  send_request(MODE_CHAR, 8'(CH_ZERO + (v / 10) % 10));
          send_request(MODE_CHAR, 8'(CH_ZERO + v % 10));
          // terminator, sometimes broken by a random byte
          r = $urandom_range(0, 9);
          send_request(MODE_CHAR, (r < 5) ? CH_CR : (r < 9) ? CH_LF : 8'($urandom));
        end
      end
    end

    drain_block();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Run: %0d requests, %0d responses checked, %0d register settings.",
             n_sent, checked, NUM_PHASES + 1);
    $display("Included a %0d-cycle output hold-off and a gap-free phase.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
